// File: design/i2cms_pkg.sv
package i2cms_pkg;

  // Command codes carried in the kind field of an input transaction.
  typedef enum logic [3:0] {
    CMD_IDLE    = 4'd0,
    CMD_START   = 4'd1,
    CMD_STOP    = 4'd2,
    CMD_WRITE   = 4'd3,
    CMD_READ    = 4'd4,
    CMD_WAIT    = 4'd5,
    CMD_ACK     = 4'd6,
    CMD_NACK    = 4'd7,
    CMD_RELEASE = 4'd8
  } cmd_t;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
  localparam int unsigned MSB_BIT          = 7;

  // Sequencer state held between transactions.
  typedef struct packed {
    cmd_t       command;
    logic [2:0] phase;
    logic [7:0] wait_count;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [7:0] rx_hold;
    logic       scl;
    logic       sda;
    logic       ack;
  } seq_state_t;

  // One result transaction, last field in the lowest bits.
  typedef struct packed {
    logic       rejected;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl_drive;
  } res_t;

endpackage

// File: design/i2cms_step.sv
module i2cms_step (
  input  i2cms_pkg::seq_state_t state,
  input  logic [7:0]            half_period,
  input  logic [3:0]            kind,
  input  logic [7:0]            tx_byte,
  input  logic                  sda_level,
  output i2cms_pkg::seq_state_t state_next,
  output i2cms_pkg::res_t       res
);

  // Sets the pin levels of the phase that the state points at and reloads the hold count.
  function automatic i2cms_pkg::seq_state_t enter_phase(i2cms_pkg::seq_state_t st,
                                                        logic [7:0] hp);
    i2cms_pkg::seq_state_t r;
    r = st;
    r.wait_count = hp;
    unique case (st.command)
      i2cms_pkg::CMD_START: begin
        priority if (st.phase == 3'd0) r.sda = 1'b1;
        else if (st.phase == 3'd1) r.scl = 1'b1;
        else if (st.phase == 3'd2) r.sda = 1'b0;
        else r.scl = 1'b0;
      end
      i2cms_pkg::CMD_STOP: begin
        if (st.phase == 3'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b0;
        end else begin
          r.scl = 1'b1;
        end
      end
      i2cms_pkg::CMD_WRITE: begin
        priority if (st.phase == 3'd0) begin
          r.scl = 1'b0;
          r.sda = st.shift_reg[i2cms_pkg::MSB_BIT];
        end else if (st.phase == 3'd1) r.scl = 1'b1;
        else r.scl = 1'b0;
      end
      i2cms_pkg::CMD_READ: r.scl = (st.phase == 3'd0);
      default: begin
        priority if (st.phase == 3'd0) r.sda = (st.command != i2cms_pkg::CMD_ACK);
        else if (st.phase == 3'd1) r.scl = 1'b1;
        else r.scl = 1'b0;
      end
    endcase
    return r;
  endfunction

  logic                  is_cmd;
  logic                  fin;
  logic                  restart;
  logic                  done;
  logic                  rej;
  logic [3:0]            bc_inc;
  i2cms_pkg::seq_state_t n;

  assign is_cmd = (kind >= i2cms_pkg::CMD_START) && (kind <= i2cms_pkg::CMD_RELEASE);
  assign bc_inc = state.bit_count + 4'd1;

  always_comb begin
    n       = state;
    fin     = 1'b0;
    restart = 1'b0;
    done    = 1'b0;
    rej     = 1'b0;
    priority if (state.command == i2cms_pkg::CMD_IDLE) begin
      if (is_cmd) begin
        n.command   = i2cms_pkg::cmd_t'(kind);
        n.phase     = 3'd0;
        n.bit_count = 4'd0;
        if (kind == i2cms_pkg::CMD_WRITE) n.shift_reg = tx_byte;
        if (kind == i2cms_pkg::CMD_READ) begin
          n.shift_reg = 8'd0;
          n.sda       = 1'b1;
        end
        n = enter_phase(n, half_period);
      end
    end else if (is_cmd) begin
      rej = 1'b1;
    end else if (state.wait_count != 8'd0) begin
      n.wait_count = state.wait_count - 8'd1;
    end else begin
      // End of the current phase.
      unique case (state.command)
        i2cms_pkg::CMD_START: fin = (state.phase >= 3'd3);
        i2cms_pkg::CMD_STOP: begin
          if (state.phase >= 3'd1) begin
            n.sda = 1'b1;
            fin   = 1'b1;
          end
        end
        i2cms_pkg::CMD_WRITE: begin
          if (state.phase >= 3'd2) begin
            n.shift_reg = {state.shift_reg[6:0], 1'b0};
            n.bit_count = bc_inc;
            if (bc_inc >= i2cms_pkg::BITS_PER_BYTE) begin
              n.sda = 1'b1;
              fin   = 1'b1;
            end else begin
              restart = 1'b1;
            end
          end
        end
        i2cms_pkg::CMD_READ: begin
          if (state.phase == 3'd0) begin
            n.shift_reg = {state.shift_reg[6:0], sda_level};
          end else begin
            n.bit_count = bc_inc;
            if (bc_inc >= i2cms_pkg::BITS_PER_BYTE) begin
              n.rx_hold = state.shift_reg;
              fin       = 1'b1;
            end else begin
              restart = 1'b1;
            end
          end
        end
        i2cms_pkg::CMD_RELEASE: begin
          if (state.phase >= 3'd1) begin
            n.scl = 1'b0;
            fin   = 1'b1;
          end
        end
        default: begin
          if (state.phase == 3'd1 && state.command == i2cms_pkg::CMD_WAIT) n.ack = sda_level;
          if (state.phase >= 3'd2) begin
            if (state.command == i2cms_pkg::CMD_ACK) n.sda = 1'b1;
            fin = 1'b1;
          end
        end
      endcase
      priority if (fin) begin
        n.command    = i2cms_pkg::CMD_IDLE;
        n.phase      = 3'd0;
        n.wait_count = 8'd0;
        done         = 1'b1;
      end else if (restart) begin
        n.phase = 3'd0;
        n     = enter_phase(n, half_period);
      end else begin
        n.phase = state.phase + 3'd1;
        n     = enter_phase(n, half_period);
      end
    end
  end

  assign state_next = n;

  always_comb begin
    res.scl_drive = n.scl;
    res.sda_drive = n.sda;
    res.busy_res  = (n.command != i2cms_pkg::CMD_IDLE);
    res.done_res  = done;
    res.rx_byte   = n.rx_hold;
    res.ack_seen  = n.ack;
    res.rejected  = rej;
  end

endmodule

// File: design/i2cms_out_buf.sv
module i2cms_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cms_pkg::res_t push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cms_pkg::res_t out_data
);

  logic            skid_valid;
  i2cms_pkg::res_t skid_data;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // The skid stage only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output stage is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid_data))
    else $error("skid stage lost a result");

  a_full_not_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && push |=> !push_ready)
    else $error("buffer accepted past its depth");

endmodule

// File: design/i2c_master_bit_sequencer_core.sv
// A result transaction is offered on the master side from the output stage registers.
// Throughput: one input per cycle; a two-entry output stage absorbs stalls until it is full.
// The sequencer state update is combinational logic between the state and output registers.
// Reset (rst, synchronous, active high) idles the sequencer with SCL and SDA released,
// empties the output stage and sets half_period to 5.
module i2c_master_bit_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // Input transactions: a command or a tick.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [7:0] tx_byte, [8] sda_level, [15:9] zero
  input  logic [3:0]  s_tuser,  // [3:0] kind
  // Result transactions, one for every input transaction.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_seen, [13] rejected, [15:14] zero
  output logic [15:0] m_tdata,
  // Configuration port; half_period lives at byte address 0.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                  in_accept;
  logic [7:0]            half_period;
  i2cms_pkg::seq_state_t state;
  i2cms_pkg::seq_state_t state_next;
  i2cms_pkg::res_t       step_res;
  i2cms_pkg::res_t       out_res;
  logic                  buf_ready;

  // The APB port never waits. Only the word at address zero holds a register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, half_period} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cms_pkg::HALF_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      half_period <= pwdata[7:0];
    end
  end

  // Each transaction moves the sequencer at most one step: a command enters
  // its first pin phase if idle and is rejected if busy, a tick counts down
  // the hold time or ends the phase. The next state is one pass of logic.
  i2cms_step u_step (
    .state       (state),
    .half_period (half_period),
    .kind        (s_tuser),
    .tx_byte     (s_tdata[7:0]),
    .sda_level   (s_tdata[8]),
    .state_next  (state_next),
    .res         (step_res)
  );

  assign s_tready  = buf_ready;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.command    <= i2cms_pkg::CMD_IDLE;
      state.phase      <= 3'd0;
      state.wait_count <= 8'd0;
      state.bit_count  <= 4'd0;
      state.shift_reg  <= 8'd0;
      state.rx_hold    <= 8'd0;
      state.scl        <= 1'b1;
      state.sda        <= 1'b1;
      state.ack        <= 1'b0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // The output stage keeps taking results while the master side stalls, so
  // the input side only waits once two results are queued.
  i2cms_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .push_data  (step_res),
    .push_ready (buf_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_res)
  );

  assign m_tdata = {2'b00, out_res};

  // An idle sequencer has no phase in flight.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state.command == i2cms_pkg::CMD_IDLE |-> state.phase == 3'd0 && state.wait_count == 8'd0)
    else $error("idle sequencer with a phase in flight");

  // A byte command never counts past eight bits.
  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    state.bit_count <= i2cms_pkg::BITS_PER_BYTE)
    else $error("bit count beyond one byte");

  // A command that finishes leaves the sequencer idle, and a rejected
  // command cannot finish one.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && step_res.done_res |-> !step_res.busy_res && !step_res.rejected)
    else $error("finished command still busy or rejected");

  // A rejected command leaves the state untouched apart from nothing at all.
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    in_accept && step_res.rejected |=> state == $past(state))
    else $error("rejected command changed the sequencer state");

endmodule

// File: verif/tb_i2c_master_bit_sequencer_core.sv
module tb_i2c_master_bit_sequencer_core;

  // Kinds above the last command code are not commands. While idle the sequencer ignores
  // them, and while busy it treats them as ticks.
  localparam logic [3:0] KIND_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] KIND_UNKNOWN_HI = 4'd15;
  localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 4;

  // How the SDA level is set on the ticks that follow a command.
  typedef enum {SDA_ALL_LOW, SDA_ALL_HIGH, SDA_RANDOM} sda_pattern_t;

  // One input transaction. A kind of CMD_IDLE is a plain tick.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] tx_byte;
    logic       sda_level;
  } bus_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // [7:0] tx_byte, [8] sda_level, [15:9] zero
  logic [3:0]  s_tuser = '0;  // [3:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_seen, [13] rejected, [15:14] zero
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_bit_sequencer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Transactions waiting to be sent, and the results predicted for the ones already taken.
  bus_item_t           bus_items_q[$];
  i2cms_pkg::res_t     expected_results_q[$];

  int queued_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Idling bounds, changed between phases of the run. A bound of zero gives a stretch with
  // no idling on that side.
  int send_gap_max = 9;
  int recv_stall_max = 9;
  int send_wait = 0;
  int recv_wait = 0;
  logic took_item = 1'b0;
  logic result_taken = 1'b0;

  // Predicted sequencer state. half_period_cfg follows every register write at the edge at
  // which the block takes it.
  i2cms_pkg::cmd_t seq_cmd;
  logic [2:0]      seq_phase;
  logic [7:0]      hold_ticks;
  logic [3:0]      bits_shifted;
  logic [7:0]      shifter;
  logic [7:0]      rx_last;
  logic            scl_lvl;
  logic            sda_lvl;
  logic            ack_lvl;
  logic [7:0]      half_period_cfg;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_sequencer_model();
    seq_cmd = i2cms_pkg::CMD_IDLE;
    seq_phase = '0;
    hold_ticks = '0;
    bits_shifted = '0;
    shifter = '0;
    rx_last = '0;
    scl_lvl = 1'b1;
    sda_lvl = 1'b1;
    ack_lvl = 1'b0;
    half_period_cfg = i2cms_pkg::HALF_PERIOD_RESET;
  endfunction

  // Sets the pin levels for the phase just entered and reloads the hold counter. The hold
  // counter takes the register value current at entry, so a write in the middle of a phase
  // only shows from the next phase on.
  function automatic void load_phase_levels();
    hold_ticks = half_period_cfg;
    case (seq_cmd)
      i2cms_pkg::CMD_START: begin
        case (seq_phase)
          3'd0: sda_lvl = 1'b1;
          3'd1: scl_lvl = 1'b1;
          3'd2: sda_lvl = 1'b0;
          default: scl_lvl = 1'b0;
        endcase
      end
      i2cms_pkg::CMD_STOP: begin
        if (seq_phase == 3'd0) begin
          scl_lvl = 1'b0;
          sda_lvl = 1'b0;
        end else begin
          scl_lvl = 1'b1;
        end
      end
      i2cms_pkg::CMD_WRITE: begin
        if (seq_phase == 3'd0) begin
          scl_lvl = 1'b0;
          sda_lvl = shifter[7];
        end else begin
          scl_lvl = (seq_phase == 3'd1);
        end
      end
      i2cms_pkg::CMD_READ: scl_lvl = (seq_phase == 3'd0);
      default: begin
        // Wait for ACK, send ACK, send NACK and release share one phase list.
        if (seq_phase == 3'd0) begin
          sda_lvl = (seq_cmd != i2cms_pkg::CMD_ACK);
        end else begin
          scl_lvl = (seq_phase == 3'd1);
        end
      end
    endcase
  endfunction

  // Closes the current phase on a tick with an expired hold count. Returns 1 when the
  // command completes on this tick.
  function automatic logic finish_phase(input logic sda_in);
    logic fin;
    fin = 1'b0;
    case (seq_cmd)
      i2cms_pkg::CMD_START: fin = (seq_phase >= 3'd3);
      i2cms_pkg::CMD_STOP: begin
        if (seq_phase >= 3'd1) begin
          sda_lvl = 1'b1;
          fin = 1'b1;
        end
      end
      i2cms_pkg::CMD_WRITE: begin
        if (seq_phase >= 3'd2) begin
          shifter = shifter << 1;
          bits_shifted = bits_shifted + 4'd1;
          if (bits_shifted >= i2cms_pkg::BITS_PER_BYTE) begin
            sda_lvl = 1'b1;
            fin = 1'b1;
          end else begin
            seq_phase = 3'd0;
            load_phase_levels();
            return 1'b0;
          end
        end
      end
      i2cms_pkg::CMD_READ: begin
        // SDA is taken at the end of the phase in which SCL is high.
        if (seq_phase == 3'd0) begin
          shifter = {shifter[6:0], sda_in};
        end else begin
          bits_shifted = bits_shifted + 4'd1;
          if (bits_shifted >= i2cms_pkg::BITS_PER_BYTE) begin
            rx_last = shifter;
            fin = 1'b1;
          end else begin
            seq_phase = 3'd0;
            load_phase_levels();
            return 1'b0;
          end
        end
      end
      i2cms_pkg::CMD_RELEASE: begin
        if (seq_phase >= 3'd1) begin
          scl_lvl = 1'b0;
          fin = 1'b1;
        end
      end
      default: begin
        if (seq_phase == 3'd1 && seq_cmd == i2cms_pkg::CMD_WAIT) ack_lvl = sda_in;
        if (seq_phase >= 3'd2) begin
          if (seq_cmd == i2cms_pkg::CMD_ACK) sda_lvl = 1'b1;
          fin = 1'b1;
        end
      end
    endcase
    if (fin) begin
      seq_cmd = i2cms_pkg::CMD_IDLE;
      seq_phase = 3'd0;
      hold_ticks = '0;
      return 1'b1;
    end
    seq_phase = seq_phase + 3'd1;
    load_phase_levels();
    return 1'b0;
  endfunction

  // Advances the predicted sequencer by one input transaction and returns the result that
  // the block must send for it.
  function automatic i2cms_pkg::res_t predict_bus_item(input logic [3:0] kind,
                                                       input logic [7:0] tx,
                                                       input logic sda_in);
    i2cms_pkg::res_t r;
    logic finished;
    logic dropped;
    logic is_cmd;
    finished = 1'b0;
    dropped = 1'b0;
    is_cmd = (kind >= i2cms_pkg::CMD_START) && (kind <= i2cms_pkg::CMD_RELEASE);
    if (seq_cmd == i2cms_pkg::CMD_IDLE) begin
      if (is_cmd) begin
        seq_cmd = i2cms_pkg::cmd_t'(kind);
        seq_phase = 3'd0;
        bits_shifted = '0;
        if (kind == i2cms_pkg::CMD_WRITE) shifter = tx;
        if (kind == i2cms_pkg::CMD_READ) begin
          shifter = '0;
          sda_lvl = 1'b1;
        end
        load_phase_levels();
      end
    end else if (is_cmd) begin
      dropped = 1'b1;
    end else if (hold_ticks != 0) begin
      hold_ticks = hold_ticks - 8'd1;
    end else begin
      finished = finish_phase(sda_in);
    end
    r.scl_drive = scl_lvl;
    r.sda_drive = sda_lvl;
    r.busy_res = (seq_cmd != i2cms_pkg::CMD_IDLE);
    r.done_res = finished;
    r.rx_byte = rx_last;
    r.ack_seen = ack_lvl;
    r.rejected = dropped;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  function automatic void compare_result(input i2cms_pkg::res_t want, input logic [15:0] raw);
    i2cms_pkg::res_t got;
    got = i2cms_pkg::res_t'(raw[13:0]);
    check_field("scl_drive", 8'(want.scl_drive), 8'(got.scl_drive));
    check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
    check_field("rx_byte", want.rx_byte, got.rx_byte);
    check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
    check_field("rejected", 8'(want.rejected), 8'(got.rejected));
  endfunction

  // Number of pin phases each command walks through.
  function automatic int phases_of(input logic [3:0] kind);
    case (kind)
      i2cms_pkg::CMD_START: return 4;
      i2cms_pkg::CMD_STOP: return 2;
      i2cms_pkg::CMD_WRITE: return 24;
      i2cms_pkg::CMD_READ: return 16;
      i2cms_pkg::CMD_RELEASE: return 2;
      default: return 3;
    endcase
  endfunction

  function automatic void push_item(input logic [3:0] kind, input logic [7:0] tx,
                                    input logic sda);
    bus_items_q.push_back('{kind, tx, sda});
    queued_count++;
  endfunction

  // Queues a command and the ticks that walk it to its end, plus a few idle ticks. When cut
  // short, ticks may stop early so that the next command arrives while the sequencer is still
  // busy and gets dropped. In noisy mode some ticks carry an unknown kind and now and then a
  // stray command is slipped in while the sequencer is most likely busy.
  function automatic void push_command(input logic [3:0] kind, input logic [7:0] tx,
                                       input sda_pattern_t pattern, input bit cut_short,
                                       input bit noisy);
    int ticks_needed;
    int ticks;
    logic [3:0] tick_kind;
    logic sda;
    ticks_needed = phases_of(kind) * (int'(half_period_cfg) + 1);
    ticks = cut_short ? $urandom_range(0, ticks_needed) : ticks_needed + $urandom_range(0, 2);
    push_item(kind, tx, 1'($urandom));
    for (int i = 0; i < ticks; i++) begin
      tick_kind = i2cms_pkg::CMD_IDLE;
      if (noisy && $urandom_range(0, 24) == 0) begin
        tick_kind = 4'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI));
      end
      if (noisy && i < ticks_needed && $urandom_range(0, 49) == 0) begin
        push_item(4'($urandom_range(i2cms_pkg::CMD_START, i2cms_pkg::CMD_RELEASE)),
                  8'($urandom), 1'($urandom));
      end
      case (pattern)
        SDA_ALL_LOW: sda = 1'b0;
        SDA_ALL_HIGH: sda = 1'b1;
        default: sda = 1'($urandom);
      endcase
      push_item(tick_kind, 8'($urandom), sda);
    end
  endfunction

  function automatic bit cut_this_time();
    return $urandom_range(0, 19) == 0;
  endfunction

  // A bus transfer as software would issue it: start, address byte, ACK check, a few data
  // bytes in either direction, stop.
  function automatic void push_random_frame();
    int n_bytes;
    n_bytes = $urandom_range(0, 3);
    push_command(i2cms_pkg::CMD_START, 8'($urandom), SDA_RANDOM, cut_this_time(), 1'b1);
    push_command(i2cms_pkg::CMD_WRITE, 8'($urandom), SDA_RANDOM, cut_this_time(), 1'b1);
    push_command(i2cms_pkg::CMD_WAIT, 8'($urandom), SDA_RANDOM, cut_this_time(), 1'b1);
    repeat (n_bytes) begin
      if ($urandom_range(0, 1) == 1) begin
        push_command(i2cms_pkg::CMD_WRITE, 8'($urandom), SDA_RANDOM, cut_this_time(), 1'b1);
        push_command(i2cms_pkg::CMD_WAIT, 8'($urandom), SDA_RANDOM, cut_this_time(), 1'b1);
      end else begin
        push_command(i2cms_pkg::CMD_READ, 8'($urandom), SDA_RANDOM, cut_this_time(), 1'b1);
        case ($urandom_range(0, 2))
          0: push_command(i2cms_pkg::CMD_ACK, 8'($urandom), SDA_RANDOM, cut_this_time(),
                          1'b1);
          1: push_command(i2cms_pkg::CMD_NACK, 8'($urandom), SDA_RANDOM, cut_this_time(),
                          1'b1);
          default: push_command(i2cms_pkg::CMD_RELEASE, 8'($urandom), SDA_RANDOM,
                                cut_this_time(), 1'b1);
        endcase
      end
    end
    push_command(i2cms_pkg::CMD_STOP, 8'($urandom), SDA_RANDOM, cut_this_time(), 1'b1);
  endfunction

  // Mostly well-formed transfers; the rest is any kind at all, often cut short.
  function automatic void push_random_traffic(input int item_goal);
    int first_count;
    first_count = queued_count;
    while (queued_count - first_count < item_goal) begin
      if ($urandom_range(0, 9) < 8) begin
        push_random_frame();
      end else begin
        push_command(4'($urandom_range(0, 15)), 8'($urandom), SDA_RANDOM,
                     1'($urandom), 1'b1);
      end
    end
  endfunction

  // Writes half_period when asked, then reads it back. Only called with no transaction in
  // flight, though the sequencer itself may still be in the middle of a command.
  task automatic access_half_period(input bit do_write, input logic [7:0] value);
    if (do_write) begin
      @(negedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_HALF_PERIOD;
      pwdata <= {24'd0, value};
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      half_period_cfg = value;
    end
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_HALF_PERIOD;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, value}) begin
      mismatch_count++;
      $display("%0t: half_period read-back mismatch, expected %0h, got %0h",
               $time, {24'd0, value}, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every queued transaction has gone and every predicted
  // result has come back.
  task automatic wait_for_idle_bus();
    while (bus_items_q.size() != 0 || s_tvalid || expected_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_max, input int recv_max);
    send_gap_max = send_max;
    recv_stall_max = recv_max;
  endtask

  // Sender. A new transaction is put up at the falling edge once the previous one was taken
  // and its drawn gap has run out.
  always @(negedge clk) begin
    bus_item_t staged;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_item) begin
      if (send_wait != 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (bus_items_q.size() != 0) begin
        staged = bus_items_q.pop_front();
        s_tuser <= staged.kind;
        s_tdata <= {7'd0, staged.sda_level, staged.tx_byte};
        s_tvalid <= 1'b1;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. A stall length is drawn for every result taken.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (result_taken) recv_wait = $urandom_range(0, recv_stall_max);
      if (recv_wait != 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor. Results are checked before the prediction for an input taken on the same edge
  // is queued; that prediction can only be answered from the next edge on.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transaction with none expected, got %0h", $time, m_tdata);
        end else begin
          compare_result(expected_results_q.pop_front(), m_tdata);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results_q.push_back(predict_bus_item(s_tuser, s_tdata[7:0], s_tdata[8]));
      end
    end
    took_item <= !rst && s_tvalid && s_tready;
    result_taken <= !rst && m_tvalid && m_tready;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_i2c_master_bit_sequencer_core failed");
      $finish;
    end
  end

  initial begin
    reset_sequencer_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The register must come out of reset at its default, and a short sequence runs at it.
    access_half_period(1'b0, i2cms_pkg::HALF_PERIOD_RESET);
    push_command(i2cms_pkg::CMD_START, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_STOP, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    wait_for_idle_bus();

    // Directed pass at the fastest setting: every command, extreme data bytes, both ACK
    // outcomes, unknown kinds and ticks while idle, and commands dropped while busy.
    access_half_period(1'b1, 8'd0);
    push_command(i2cms_pkg::CMD_START, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_WRITE, 8'hFF, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_WAIT, 8'h00, SDA_ALL_LOW, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_WRITE, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_WAIT, 8'hFF, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_READ, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_ACK, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_READ, 8'hFF, SDA_ALL_LOW, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_NACK, 8'h00, SDA_ALL_LOW, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_RELEASE, 8'h00, SDA_ALL_LOW, 1'b0, 1'b0);
    push_command(i2cms_pkg::CMD_STOP, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    push_item(KIND_UNKNOWN_LO, 8'hFF, 1'b1);
    push_item(KIND_UNKNOWN_HI, 8'h00, 1'b0);
    push_item(i2cms_pkg::CMD_IDLE, 8'h5A, 1'b1);
    push_item(i2cms_pkg::CMD_START, 8'h00, 1'b0);
    push_item(i2cms_pkg::CMD_WRITE, 8'hA5, 1'b1);
    push_item(KIND_UNKNOWN_HI, 8'h00, 1'b0);
    repeat (4) push_item(i2cms_pkg::CMD_IDLE, 8'h00, 1'b1);
    push_command(i2cms_pkg::CMD_STOP, 8'h00, SDA_ALL_HIGH, 1'b0, 1'b0);
    wait_for_idle_bus();

    set_idling(9, 9);
    push_random_traffic(40);
    wait_for_idle_bus();

    // Change the register while a start is held in its second phase. The phase in progress
    // keeps its old hold count; the later phases take the new one.
    access_half_period(1'b1, 8'd3);
    push_item(i2cms_pkg::CMD_START, 8'h00, 1'b1);
    repeat (6) push_item(i2cms_pkg::CMD_IDLE, 8'h00, 1'b1);
    wait_for_idle_bus();
    access_half_period(1'b1, 8'd1);
    repeat (12) push_item(i2cms_pkg::CMD_IDLE, 8'h00, 1'b1);
    wait_for_idle_bus();

    access_half_period(1'b1, 8'd0);
    set_idling(0, 9);
    push_random_traffic(30);
    wait_for_idle_bus();

    // Slowest setting: the first phase of a start holds for the full count from the top
    // value. The register drops back to zero midway, so the later phases run fast.
    access_half_period(1'b1, 8'd255);
    set_idling(0, 0);
    push_item(i2cms_pkg::CMD_START, 8'h00, 1'b1);
    repeat (200) push_item(i2cms_pkg::CMD_IDLE, 8'h00, 1'($urandom));
    wait_for_idle_bus();
    access_half_period(1'b1, 8'd0);
    repeat (62) push_item(i2cms_pkg::CMD_IDLE, 8'h00, 1'($urandom));
    push_command(i2cms_pkg::CMD_STOP, 8'h00, SDA_RANDOM, 1'b0, 1'b0);
    wait_for_idle_bus();

    set_idling(9, 0);
    push_random_traffic(30);
    wait_for_idle_bus();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_i2c_master_bit_sequencer_core passed");
    end else begin
      $display("tb_i2c_master_bit_sequencer_core failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/i2cms_pkg.sv
design/i2cms_step.sv
design/i2cms_out_buf.sv
design/i2c_master_bit_sequencer_core.sv
verif/tb_i2c_master_bit_sequencer_core.sv
